// ===== rtl/sm64bd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SplitMix64 bounded draw package
// Shared widths, register map and mixing constants of the bounded draw block.
// ----------------------------------------------------------------------------
package sm64bd_pkg;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned HALF_W     = DATA_W / 2;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned CNT_W      = $clog2(DATA_W);

  typedef logic [DATA_W-1:0]     word_t;
  typedef logic [APB_ADDR_W-1:0] apb_addr_t;

  // Register map: the seed register sits at byte address zero.
  localparam apb_addr_t SEED_ADDR = apb_addr_t'(0);

  localparam word_t GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam word_t MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam word_t MIX_MUL_B    = 64'h94D049BB133111EB;

  localparam int unsigned MIX_SHIFT_A = 30;
  localparam int unsigned MIX_SHIFT_B = 27;
  localparam int unsigned MIX_SHIFT_C = 31;

endpackage

// ===== rtl/splitmix64_bounded_draw_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SplitMix64 bounded draw
// Unbiased bounded random draws from a SplitMix64 generator, by rejection.
// ----------------------------------------------------------------------------
// How to use this block:
// A request transaction on the slave stream carries an exclusive upper bound.
// For each request exactly one response transaction leaves on the master
// stream, holding a value in the range zero to bound minus one. A bound of
// zero answers zero and leaves the generator state alone.
// The APB port holds one 64-bit register, the seed, at address zero. Writing
// it also loads the running generator state. Write it only while idle.
// A nonzero bound first runs the shared one-bit-per-cycle remainder unit
// for the rejection limit, then draws words through the shared 32x32
// multiplier, which builds each 64-bit mixing product from three partial
// products, until one is accepted, and last runs the remainder unit again
// for the final modulo. Each rejected word costs one more draw.
// A new request is taken in the cycle after the previous response is
// loaded; the block never works on two requests at once.
// Reset clears the seed and the generator state to zero and empties the
// response register. When the receiver stalls, the response waits in its
// output register; the next request may be accepted and computed meanwhile,
// and its result is held back until the output register frees up.
// ----------------------------------------------------------------------------
module splitmix64_bounded_draw_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request stream. tdata: [63:0] upper_bound.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sm64bd_pkg::DATA_W-1:0] s_axis_tdata,
  // Response stream. tdata: [63:0] draw.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sm64bd_pkg::DATA_W-1:0] m_axis_tdata,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sm64bd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sm64bd_pkg::DATA_W-1:0]     pwdata,
  output logic [sm64bd_pkg::DATA_W-1:0]     prdata,
  output logic                              pready
);

  import sm64bd_pkg::*;

  // Sequencer states. LIMIT and MODW run the shared remainder unit; MULA and
  // MULB run the shared multiplier.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_ADV,
    ST_MULA,
    ST_XS2,
    ST_MULB,
    ST_FIN,
    ST_MODW,
    ST_OUT
  } state_e;

  state_e                 state_q;
  word_t                  seed_q;
  word_t                  gen_q;
  word_t                  bound_q;
  word_t                  limit_q;
  word_t                  z_q;
  word_t                  acc_q;
  word_t                  rem_q;
  word_t                  dvd_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [DATA_W-1:0]      mul_q;
  logic                   out_valid_q;
  word_t                  out_data_q;

  // Configuration port: always ready, writes complete in the access cycle.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == SEED_ADDR);
  assign prdata = (paddr == SEED_ADDR) ? seed_q : '0;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Shared remainder unit: one restoring step per cycle.
  logic [DATA_W:0] rem_trial;
  logic [DATA_W:0] rem_diff;
  word_t           rem_next;
  assign rem_trial = {rem_q, dvd_q[DATA_W-1]};
  assign rem_diff  = rem_trial - {1'b0, bound_q};
  // A set top bit means the trial stayed below the bound.
  assign rem_next  = rem_diff[DATA_W] ? rem_trial[DATA_W-1:0] : rem_diff[DATA_W-1:0];

  // Shared 32x32 multiplier. The mixing product modulo 2^64 is
  // lo*lo + ((lo*hi + hi*lo) << 32), issued over steps zero to two.
  word_t             mul_const;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [1:0]        mstep;
  assign mstep     = cnt_q[1:0];
  assign mul_const = (state_q == ST_MULA) ? MIX_MUL_A : MIX_MUL_B;
  assign mul_a     = (mstep == 2'd2) ? z_q[DATA_W-1:HALF_W] : z_q[HALF_W-1:0];
  assign mul_b     = (mstep == 2'd1) ? mul_const[DATA_W-1:HALF_W] : mul_const[HALF_W-1:0];

  always_ff @(posedge clk_i) begin
    mul_q <= DATA_W'(mul_a) * DATA_W'(mul_b);
  end

  // Mixing steps outside the multiplier.
  word_t gen_sum;
  word_t word_fin;
  assign gen_sum  = gen_q + GOLDEN_GAMMA;
  assign word_fin = z_q ^ (z_q >> MIX_SHIFT_C);

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= '0;
      gen_q       <= '0;
      bound_q     <= '0;
      limit_q     <= '0;
      z_q         <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      dvd_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        seed_q <= pwdata;
        gen_q  <= pwdata;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            bound_q <= s_axis_tdata;
            rem_q   <= '0;
            dvd_q   <= '0 - s_axis_tdata;
            cnt_q   <= '0;
            state_q <= (s_axis_tdata == '0) ? ST_OUT : ST_LIMIT;
          end
        end
        ST_LIMIT, ST_MODW: begin
          rem_q <= rem_next;
          dvd_q <= dvd_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DATA_W - 1)) begin
            cnt_q <= '0;
            if (state_q == ST_LIMIT) begin
              limit_q <= rem_next;
              state_q <= ST_ADV;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_ADV: begin
          gen_q   <= gen_sum;
          z_q     <= gen_sum ^ (gen_sum >> MIX_SHIFT_A);
          cnt_q   <= '0;
          state_q <= ST_MULA;
        end
        ST_MULA, ST_MULB: begin
          cnt_q <= cnt_q + 1'b1;
          case (mstep)
            2'd0: ;
            2'd1: acc_q <= mul_q;
            2'd2: acc_q[DATA_W-1:HALF_W] <= acc_q[DATA_W-1:HALF_W] + mul_q[HALF_W-1:0];
            default: begin
              z_q     <= {acc_q[DATA_W-1:HALF_W] + mul_q[HALF_W-1:0], acc_q[HALF_W-1:0]};
              cnt_q   <= '0;
              state_q <= (state_q == ST_MULA) ? ST_XS2 : ST_FIN;
            end
          endcase
        end
        ST_XS2: begin
          z_q     <= z_q ^ (z_q >> MIX_SHIFT_B);
          state_q <= ST_MULB;
        end
        ST_FIN: begin
          // Words below the limit are rejected and a fresh one is drawn.
          if (word_fin >= limit_q) begin
            dvd_q   <= word_fin;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_MODW;
          end else begin
            state_q <= ST_ADV;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_data_q  <= rem_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sm64bd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SplitMix64 bounded draw checker
// Port-level assertions on the bounded draw block, bound to its top level.
// ----------------------------------------------------------------------------
module sm64bd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [sm64bd_pkg::DATA_W-1:0]     m_axis_tdata,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [sm64bd_pkg::APB_ADDR_W-1:0] paddr,
  input logic [sm64bd_pkg::DATA_W-1:0]     pwdata,
  input logic [sm64bd_pkg::DATA_W-1:0]     prdata
);

  import sm64bd_pkg::*;

  // A stalled response transaction stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("response dropped while stalled");

  // A stalled response transaction keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("response data changed while stalled");

  // The block works on one request at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // A new response is only loaded by the busy sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("response appeared without a request in flight");

  // A seed write reads back on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr == SEED_ADDR)
    |=> (paddr != SEED_ADDR) || (prdata == $past(pwdata)))
    else $error("seed readback mismatch");

endmodule

bind splitmix64_bounded_draw_top sm64bd_checker u_sm64bd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SplitMix64 bounded draw testbench
// Drives bound requests with random gaps and stalls the response stream at
// random. It predicts every draw with its own generator and rejection
// sampler, then compares each response transaction against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import sm64bd_pkg::*;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 10;
  // Quiet time after the last response, long enough that a stray extra
  // response would still be caught.
  localparam int unsigned SETTLE_CYCLES = 300;
  // About 600 requests, each allowed its longest gap, its longest stall and
  // a long run of rejections, taken several times over.
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned PHASE_ITEMS   = 110;

  // No register lives at byte address 8; writes there must be ignored.
  localparam apb_addr_t UNMAPPED_ADDR = apb_addr_t'(8);

  localparam word_t ALL_ONES = {DATA_W{1'b1}};
  localparam word_t TOP_BIT  = word_t'(1) << (DATA_W - 1);

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Request stream. tdata: [63:0] upper_bound.
  logic  s_axis_tvalid = 1'b0;
  logic  s_axis_tready;
  word_t s_axis_tdata  = '0;

  // Response stream. tdata: [63:0] draw.
  logic  m_axis_tvalid;
  logic  m_axis_tready = 1'b0;
  word_t m_axis_tdata;

  // Configuration port.
  logic      psel    = 1'b0;
  logic      penable = 1'b0;
  logic      pwrite  = 1'b0;
  apb_addr_t paddr   = '0;
  word_t     pwdata  = '0;
  word_t     prdata;
  logic      pready;

  splitmix64_bounded_draw_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // The shadow copy of the seed register and of the running generator state.
  word_t model_seed  = '0;
  word_t model_state = '0;

  // Bounds waiting to be sent, and the draws predicted for accepted bounds.
  word_t pending_bounds[$];
  word_t expected_draws[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  // When set, neither side idles, so requests and responses run back to back.
  bit          quiet_idle  = 1'b0;

  // The bounded draw as the block should compute it. Every generated word
  // advances the state, including the ones the rejection test throws away.
  // A zero bound answers zero and leaves the state alone.
  function automatic word_t predict_draw(input word_t bound);
    word_t limit;
    word_t z;
    if (bound == '0) begin
      return '0;
    end
    limit = (word_t'(0) - bound) % bound;
    do begin
      model_state = model_state + GOLDEN_GAMMA;
      z = model_state;
      z = (z ^ (z >> MIX_SHIFT_A)) * MIX_MUL_A;
      z = (z ^ (z >> MIX_SHIFT_B)) * MIX_MUL_B;
      z = z ^ (z >> MIX_SHIFT_C);
    end while (z < limit);
    return z % bound;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_idle || roll < 55) begin
      return 0;
    end
    if (roll < 85) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(50, 300);
  endfunction

  // Random bounds. Bounds with the top bit set give a large rejection limit,
  // so they exercise the redraw loop far more often than small ones do.
  function automatic word_t pick_bound();
    int unsigned roll;
    word_t       bound;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      bound = '0;
    end else if (roll < 12) begin
      bound = word_t'($urandom_range(1, 16));
    end else if (roll < 27) begin
      bound = word_t'($urandom_range(17, 100000));
    end else if (roll < 40) begin
      bound = word_t'($urandom);
    end else if (roll < 52) begin
      bound = (word_t'(1) << $urandom_range(0, DATA_W - 1))
            + word_t'($urandom_range(0, 2)) - word_t'(1);
    end else if (roll < 70) begin
      bound = {1'b1, 31'($urandom), 32'($urandom)};
    end else begin
      bound = {32'($urandom), 32'($urandom)};
    end
    return bound;
  endfunction

  // Request driver. On each accepted transaction the expected draw is
  // predicted right away, so the order of predictions follows the order in
  // which the block takes the bounds. Valid is held high across back-to-back
  // transactions rather than being dropped and raised in the same edge.
  always @(posedge clk_i) begin : drive_requests
    int unsigned gap_now;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      gap_left      <= 0;
    end else begin
      gap_now = gap_left;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_draws = {expected_draws, predict_draw(s_axis_tdata)};
        gap_now = pick_gap();
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // The current request is still waiting; hold it unchanged.
      end else if (gap_now != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_now - 1;
      end else if (pending_bounds.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_bounds.pop_front();
        gap_left      <= 0;
      end else begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= 0;
      end
    end
  end

  // Response monitor and receiver. Ready drops at random, whether or not a
  // response is on offer, so stalls land on every stage of the computation.
  always @(posedge clk_i) begin : check_responses
    word_t       want;
    int unsigned stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_draws.size() == 0) begin
          $error("draw: unexpected response %h with no request outstanding", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_draws.pop_front();
          if (m_axis_tdata !== want) begin
            $error("draw: expected %h, actual %h", want, m_axis_tdata);
            fail_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_idle && $urandom_range(0, 4) == 0) begin
        stall = pick_gap();
        stall_left    <= stall;
        m_axis_tready <= (stall == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake or a lost response ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL splitmix64_bounded_draw_top");
    $finish;
  end

  // One APB write: a setup cycle, then an access cycle that completes at the
  // edge where pready is high. The shadow state follows only a seed write.
  task automatic write_reg(input apb_addr_t addr, input word_t value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == SEED_ADDR) begin
      model_seed  = value;
      model_state = value;
    end
  endtask

  // One APB read of the seed register, compared against the shadow copy.
  task automatic check_seed_readback();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SEED_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== model_seed) begin
      $error("seed: expected %h, actual %h", model_seed, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every queued bound has been taken and answered, then let the
  // block settle so that a stray extra response would still be caught. The
  // condition is sampled on the falling edge, away from the driving edge.
  task automatic drain_all();
    while (pending_bounds.size() != 0 || s_axis_tvalid || expected_draws.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Stimulus: two directed groups, an ignored write to an unmapped address,
  // then random phases under different seeds, one of them without idling.
  initial begin : stimulus
    word_t phase_seeds[5];
    phase_seeds[0] = {32'($urandom), 32'($urandom)};
    phase_seeds[1] = '0;
    phase_seeds[2] = {32'($urandom), 32'($urandom)};
    phase_seeds[3] = ALL_ONES;
    phase_seeds[4] = {32'($urandom), 32'($urandom)};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The generator starts from the reset value of the seed, zero. A zero
    // bound between the others must not move the state; a bound of one
    // always answers zero but still uses up one word.
    check_seed_readback();
    pending_bounds = '{word_t'(0), word_t'(1), word_t'(2), word_t'(3), word_t'(10),
                       word_t'(64'h0000_0000_FFFF_FFFF), word_t'(64'h0000_0001_0000_0000),
                       TOP_BIT - word_t'(1), TOP_BIT, TOP_BIT + word_t'(1),
                       ALL_ONES, word_t'(0), word_t'(1)};
    drain_all();

    write_reg(SEED_ADDR, ALL_ONES);
    check_seed_readback();
    pending_bounds = '{ALL_ONES, ALL_ONES - word_t'(1), word_t'(64'hAAAA_AAAA_AAAA_AAAA),
                       word_t'(64'h5555_5555_5555_5555), TOP_BIT + word_t'(2),
                       word_t'(0), word_t'(1), word_t'(6)};
    drain_all();

    // A write outside the register map must change neither the seed nor the
    // running state; the next phase would reveal a disturbed state.
    write_reg(UNMAPPED_ADDR, {32'($urandom), 32'($urandom)});
    check_seed_readback();
    for (int i = 0; i < 4; i++) begin
      pending_bounds = {pending_bounds, pick_bound()};
    end
    drain_all();

    foreach (phase_seeds[p]) begin
      write_reg(SEED_ADDR, phase_seeds[p]);
      check_seed_readback();
      quiet_idle = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pending_bounds = {pending_bounds, pick_bound()};
      end
      drain_all();
    end

    if (fail_count == 0) begin
      $display("PASS splitmix64_bounded_draw_top");
    end else begin
      $display("FAIL splitmix64_bounded_draw_top");
    end
    $finish;
  end

endmodule
